>>> rtl/q2rm_pkg.sv
// ----------------------------------------------------------------------------
// q2rm_pkg
// Widths, stage counts and constants shared by the quaternion to rotation
// matrix pipeline and its checker.
// ----------------------------------------------------------------------------
package q2rm_pkg;

  localparam int unsigned DataWidth  = 16;
  localparam int unsigned FracBits   = 14;
  localparam int unsigned NumEntries = 9;

  // squares and cross products of two components
  localparam int unsigned ProdW = 2 * DataWidth;
  // signed numerators: twice a sum of two products
  localparam int unsigned NumW  = 2 * DataWidth + 2;
  // norm and numerator magnitudes, at most four times the largest square
  localparam int unsigned DenW  = 2 * DataWidth + 1;
  // quotient bits including the rounding bit
  localparam int unsigned QuoW  = FracBits + 2;
  // signed width used before saturation
  localparam int unsigned SatW  = QuoW + DataWidth;

  // products, sums, magnitudes, divider steps, round and saturate
  localparam int unsigned NumStages = QuoW + 4;

  // diagonal entries r00, r11, r22
  localparam logic [NumEntries-1:0] DiagMask = 9'b100010001;

  // 1.0, saturated when it does not fit
  localparam logic [DataWidth-1:0] OutOne =
    (FracBits <= DataWidth - 2) ? (DataWidth'(1) << FracBits)
                                : {1'b0, {(DataWidth - 1){1'b1}}};

endpackage

>>> rtl/quaternion_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Converts a signed fixed point quaternion (x, y, z, w) into the nine entries
// of its 3x3 rotation matrix, scaled by 2 / (xx + yy + zz + ww) so that the
// quaternion need not be of unit length. Each entry is one exact quotient,
// rounded to nearest with ties away from zero and saturated to the output
// range. A zero quaternion gives the identity matrix with degenerate set.
// The block takes one quaternion per clock unless a stall on the output has
// backed up the pipeline, and returns its Q2.14 matrix through a product stage
// for the ten products, a sum stage, a magnitude stage, the restoring divider
// stages (one quotient bit per stage, nine lanes sharing the norm as divisor)
// and a final stage for rounding and saturation. Every stage holds
// its beat when the next one is full, so stalls on the output lose nothing
// and bubbles inside the pipeline are still filled while the output waits.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [q2rm_pkg::DataWidth-1:0] quat_x_i,
  input  logic signed [q2rm_pkg::DataWidth-1:0] quat_y_i,
  input  logic signed [q2rm_pkg::DataWidth-1:0] quat_z_i,
  input  logic signed [q2rm_pkg::DataWidth-1:0] quat_w_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [q2rm_pkg::DataWidth-1:0] r00_o,
  output logic signed [q2rm_pkg::DataWidth-1:0] r01_o,
  output logic signed [q2rm_pkg::DataWidth-1:0] r02_o,
  output logic signed [q2rm_pkg::DataWidth-1:0] r10_o,
  output logic signed [q2rm_pkg::DataWidth-1:0] r11_o,
  output logic signed [q2rm_pkg::DataWidth-1:0] r12_o,
  output logic signed [q2rm_pkg::DataWidth-1:0] r20_o,
  output logic signed [q2rm_pkg::DataWidth-1:0] r21_o,
  output logic signed [q2rm_pkg::DataWidth-1:0] r22_o,
  output logic                                 degenerate_o
);

  localparam int unsigned DW   = q2rm_pkg::DataWidth;
  localparam int unsigned NE   = q2rm_pkg::NumEntries;
  localparam int unsigned PW   = q2rm_pkg::ProdW;
  localparam int unsigned NumW = q2rm_pkg::NumW;
  localparam int unsigned DenW = q2rm_pkg::DenW;
  localparam int unsigned QuoW = q2rm_pkg::QuoW;
  localparam int unsigned SatW = q2rm_pkg::SatW;
  localparam int unsigned NS   = q2rm_pkg::NumStages;

  // round half away from zero on the magnitude, apply sign, saturate
  function automatic logic [DW-1:0] round_sat(logic [QuoW-1:0] quo, logic neg);
    logic [QuoW:0]          inc;
    logic signed [SatW-1:0] val;
    logic [SatW-DW:0]       top;
    inc = {1'b0, quo} + (QuoW + 1)'(1);
    val = {{(SatW - QuoW){1'b0}}, inc[QuoW:1]};
    if (neg) begin
      val = -val;
    end
    top = val[SatW-1:DW-1];
    if ((&top) || !(|top)) begin
      return val[DW-1:0];
    end else if (val[SatW-1]) begin
      return {1'b1, {(DW - 1){1'b0}}};
    end else begin
      return {1'b0, {(DW - 1){1'b1}}};
    end
  endfunction

  // ---------------------------------------------------------------- flow
  logic [NS-1:0] stg_v_q, stg_v_d, stg_en, nxt_rdy;

  // a stage loads when it is empty or its beat moves on
  assign nxt_rdy    = {out_ready_i, stg_en[NS-1:1]};
  assign stg_en     = ~stg_v_q | nxt_rdy;
  assign stg_v_d    = {stg_v_q[NS-2:0], in_valid_i};
  assign in_ready_o = stg_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= '0;
    end else begin
      stg_v_q <= (stg_en & stg_v_d) | (~stg_en & stg_v_q);
    end
  end

  // ------------------------------------------------------------ products
  logic signed [PW-1:0] p_xx_q, p_yy_q, p_zz_q, p_ww_q, p_xy_q;
  logic signed [PW-1:0] p_xz_q, p_yz_q, p_wx_q, p_wy_q, p_wz_q;

  always_ff @(posedge clk_i) begin
    if (stg_en[0]) begin
      p_xx_q <= quat_x_i * quat_x_i;
      p_yy_q <= quat_y_i * quat_y_i;
      p_zz_q <= quat_z_i * quat_z_i;
      p_ww_q <= quat_w_i * quat_w_i;
      p_xy_q <= quat_x_i * quat_y_i;
      p_xz_q <= quat_x_i * quat_z_i;
      p_yz_q <= quat_y_i * quat_z_i;
      p_wx_q <= quat_w_i * quat_x_i;
      p_wy_q <= quat_w_i * quat_y_i;
      p_wz_q <= quat_w_i * quat_z_i;
    end
  end

  // ---------------------------------------------------------------- sums
  logic signed [NumW-1:0] e_xx, e_yy, e_zz, e_ww, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
  logic signed [NumW-1:0] sqs;
  logic signed [NumW-1:0] num_d [NE];
  logic signed [NumW-1:0] num_q [NE];
  logic [DenW-1:0]        den_q;

  assign e_xx = NumW'(p_xx_q);
  assign e_yy = NumW'(p_yy_q);
  assign e_zz = NumW'(p_zz_q);
  assign e_ww = NumW'(p_ww_q);
  assign e_xy = NumW'(p_xy_q);
  assign e_xz = NumW'(p_xz_q);
  assign e_yz = NumW'(p_yz_q);
  assign e_wx = NumW'(p_wx_q);
  assign e_wy = NumW'(p_wy_q);
  assign e_wz = NumW'(p_wz_q);
  assign sqs  = e_xx + e_yy + e_zz + e_ww;

  always_comb begin
    num_d[0] = e_ww + e_xx - e_yy - e_zz;
    num_d[1] = (e_xy + e_wz) <<< 1;
    num_d[2] = (e_xz - e_wy) <<< 1;
    num_d[3] = (e_xy - e_wz) <<< 1;
    num_d[4] = e_ww - e_xx + e_yy - e_zz;
    num_d[5] = (e_yz + e_wx) <<< 1;
    num_d[6] = (e_xz + e_wy) <<< 1;
    num_d[7] = (e_yz - e_wx) <<< 1;
    num_d[8] = e_ww - e_xx - e_yy + e_zz;
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[1]) begin
      for (int e = 0; e < NE; e++) begin
        num_q[e] <= num_d[e];
      end
      den_q <= sqs[DenW-1:0];
    end
  end

  // ------------------------------------------------------- divider lanes
  logic [DenW-1:0] dv_rem_q  [QuoW+1][NE];
  logic [QuoW-1:0] dv_quo_q  [QuoW+1][NE];
  logic [NE-1:0]   dv_neg_q  [QuoW+1];
  logic [DenW-1:0] dv_den_q  [QuoW+1];
  logic            dv_zero_q [QuoW+1];

  logic signed [NumW-1:0] num_abs [NE];

  always_comb begin
    for (int e = 0; e < NE; e++) begin
      num_abs[e] = num_q[e][NumW-1] ? -num_q[e] : num_q[e];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[2]) begin
      for (int e = 0; e < NE; e++) begin
        dv_rem_q[0][e] <= num_abs[e][DenW-1:0];
        dv_quo_q[0][e] <= '0;
        dv_neg_q[0][e] <= num_q[e][NumW-1];
      end
      dv_den_q[0]  <= den_q;
      dv_zero_q[0] <= (den_q == '0);
    end
  end

  // one quotient bit per stage; the first step takes the integer bit
  for (genvar j = 0; j < QuoW; j++) begin : g_div
    logic [DenW:0] trial [NE];
    logic [DenW:0] diff  [NE];
    logic [NE-1:0] ge;

    always_comb begin
      for (int e = 0; e < NE; e++) begin
        trial[e] = (j == 0) ? {1'b0, dv_rem_q[j][e]} : {dv_rem_q[j][e], 1'b0};
        diff[e]  = trial[e] - {1'b0, dv_den_q[j]};
        ge[e]    = (trial[e] >= {1'b0, dv_den_q[j]});
      end
    end

    always_ff @(posedge clk_i) begin
      if (stg_en[3+j]) begin
        for (int e = 0; e < NE; e++) begin
          dv_rem_q[j+1][e] <= ge[e] ? diff[e][DenW-1:0] : trial[e][DenW-1:0];
          dv_quo_q[j+1][e] <= {dv_quo_q[j][e][QuoW-2:0], ge[e]};
        end
        dv_neg_q[j+1]  <= dv_neg_q[j];
        dv_den_q[j+1]  <= dv_den_q[j];
        dv_zero_q[j+1] <= dv_zero_q[j];
      end
    end
  end

  // ---------------------------------------------------- round and output
  logic [DW-1:0] r_q [NE];
  logic          deg_q;

  always_ff @(posedge clk_i) begin
    if (stg_en[NS-1]) begin
      for (int e = 0; e < NE; e++) begin
        if (dv_zero_q[QuoW]) begin
          r_q[e] <= q2rm_pkg::DiagMask[e] ? q2rm_pkg::OutOne : '0;
        end else begin
          r_q[e] <= round_sat(dv_quo_q[QuoW][e], dv_neg_q[QuoW][e]);
        end
      end
      deg_q <= dv_zero_q[QuoW];
    end
  end

  assign out_valid_o  = stg_v_q[NS-1];
  assign r00_o        = r_q[0];
  assign r01_o        = r_q[1];
  assign r02_o        = r_q[2];
  assign r10_o        = r_q[3];
  assign r11_o        = r_q[4];
  assign r12_o        = r_q[5];
  assign r20_o        = r_q[6];
  assign r21_o        = r_q[7];
  assign r22_o        = r_q[8];
  assign degenerate_o = deg_q;

endmodule

>>> rtl/q2rm_checker.sv
// ----------------------------------------------------------------------------
// q2rm_checker
// Port level checks of the quaternion to rotation matrix pipeline, bound to
// the top level.
// ----------------------------------------------------------------------------
module q2rm_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic signed [q2rm_pkg::DataWidth-1:0] quat_x_i,
  input logic signed [q2rm_pkg::DataWidth-1:0] quat_y_i,
  input logic signed [q2rm_pkg::DataWidth-1:0] quat_z_i,
  input logic signed [q2rm_pkg::DataWidth-1:0] quat_w_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [q2rm_pkg::DataWidth-1:0] r00_o,
  input logic signed [q2rm_pkg::DataWidth-1:0] r01_o,
  input logic signed [q2rm_pkg::DataWidth-1:0] r02_o,
  input logic signed [q2rm_pkg::DataWidth-1:0] r10_o,
  input logic signed [q2rm_pkg::DataWidth-1:0] r11_o,
  input logic signed [q2rm_pkg::DataWidth-1:0] r12_o,
  input logic signed [q2rm_pkg::DataWidth-1:0] r20_o,
  input logic signed [q2rm_pkg::DataWidth-1:0] r21_o,
  input logic signed [q2rm_pkg::DataWidth-1:0] r22_o,
  input logic                                 degenerate_o
);

  logic in_beat;
  logic quat_zero;

  assign in_beat   = in_valid_i && in_ready_o;
  assign quat_zero = (quat_x_i == '0) && (quat_y_i == '0) && (quat_z_i == '0) &&
                     (quat_w_i == '0);

  // a stalled output beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable(r00_o) && $stable(r01_o) && $stable(r02_o) &&
      $stable(r10_o) && $stable(r11_o) && $stable(r12_o) &&
      $stable(r20_o) && $stable(r21_o) && $stable(r22_o) &&
      $stable(degenerate_o))
    else $error("output beat changed while stalled");

  // the pipeline only pushes back when the output is full and blocked
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ready_i || !out_valid_o) |-> in_ready_o)
    else $error("input stalled with a free output");

  // zero quaternion gives the identity
  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      r00_o == q2rm_pkg::OutOne && r11_o == q2rm_pkg::OutOne &&
      r22_o == q2rm_pkg::OutOne && r01_o == '0 && r02_o == '0 &&
      r10_o == '0 && r12_o == '0 && r20_o == '0 && r21_o == '0)
    else $error("degenerate beat is not the identity");

  // with the output never stalled, a zero quaternion comes out flagged
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && quat_zero && out_ready_i ##1
      out_ready_i [*q2rm_pkg::NumStages - 1] |=> out_valid_o && degenerate_o)
    else $error("zero quaternion not flagged");

endmodule

bind quaternion_to_rotation_matrix q2rm_checker u_q2rm_checker (.*);

>>> bench/quaternion_to_rotation_matrix_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_tb
// Drives quaternions into the rotation matrix pipeline and compares every
// matrix beat with a fixed point prediction of the nine entries and the
// degenerate flag. Corner quaternions come first, then random ones of mixed
// magnitude, while the sender idles in bursts and the receiver stalls,
// including one long hold that backs up the pipeline and one full drain.
// ----------------------------------------------------------------------------

typedef logic signed [q2rm_pkg::DataWidth-1:0] fix_t;

typedef struct packed {
  fix_t x;
  fix_t y;
  fix_t z;
  fix_t w;
} quat_t;

// entry index is row * 3 + column
typedef struct packed {
  fix_t [q2rm_pkg::NumEntries-1:0] entry;
  logic                            degenerate;
} matrix_t;

class matrix_scoreboard;
  matrix_t     expected_matrices[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned identities;

  function new();
    errors     = 0;
    checked    = 0;
    identities = 0;
  endfunction

  // round(num / norm) to FracBits fraction bits, ties away from zero
  function fix_t scaled_ratio(longint num, longint norm);
    longint mag;
    longint quo;
    longint val;
    longint lim_hi;
    longint lim_lo;
    mag = (num < 0) ? -num : num;
    quo = (mag <<< (q2rm_pkg::FracBits + 1)) / norm;
    val = (quo + 1) >>> 1;
    if (num < 0) val = -val;
    lim_hi = (longint'(1) <<< (q2rm_pkg::DataWidth - 1)) - 1;
    lim_lo = -lim_hi - 1;
    if (val > lim_hi) val = lim_hi;
    if (val < lim_lo) val = lim_lo;
    return fix_t'(val);
  endfunction

  function void note_quat(quat_t q);
    longint  x, y, z, w;
    longint  xx, yy, zz, ww, xy, xz, yz, wx, wy, wz, norm;
    matrix_t m;
    x  = longint'($signed(q.x));
    y  = longint'($signed(q.y));
    z  = longint'($signed(q.z));
    w  = longint'($signed(q.w));
    xx = x * x;
    yy = y * y;
    zz = z * z;
    ww = w * w;
    xy = x * y;
    xz = x * z;
    yz = y * z;
    wx = w * x;
    wy = w * y;
    wz = w * z;
    norm = xx + yy + zz + ww;
    m = '0;
    if (norm == 0) begin
      m.entry[0]   = q2rm_pkg::OutOne;
      m.entry[4]   = q2rm_pkg::OutOne;
      m.entry[8]   = q2rm_pkg::OutOne;
      m.degenerate = 1'b1;
    end else begin
      m.entry[0] = scaled_ratio(ww + xx - yy - zz, norm);
      m.entry[1] = scaled_ratio(2 * (xy + wz), norm);
      m.entry[2] = scaled_ratio(2 * (xz - wy), norm);
      m.entry[3] = scaled_ratio(2 * (xy - wz), norm);
      m.entry[4] = scaled_ratio(ww - xx + yy - zz, norm);
      m.entry[5] = scaled_ratio(2 * (yz + wx), norm);
      m.entry[6] = scaled_ratio(2 * (xz + wy), norm);
      m.entry[7] = scaled_ratio(2 * (yz - wx), norm);
      m.entry[8] = scaled_ratio(ww - xx - yy + zz, norm);
    end
    expected_matrices.push_back(m);
  endfunction

  function void check_matrix(matrix_t got);
    matrix_t want;
    if (expected_matrices.size() == 0) begin
      $error("matrix beat with no quaternion outstanding");
      errors++;
      return;
    end
    want = expected_matrices.pop_front();
    checked++;
    if (want.degenerate) identities++;
    for (int k = 0; k < q2rm_pkg::NumEntries; k++) begin
      if (got.entry[k] !== want.entry[k]) begin
        $error("r%0d%0d: expected %0d, actual %0d", k / 3, k % 3,
               $signed(want.entry[k]), $signed(got.entry[k]));
        errors++;
      end
    end
    if (got.degenerate !== want.degenerate) begin
      $error("degenerate: expected %0b, actual %0b", want.degenerate, got.degenerate);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_matrices.size();
  endfunction
endclass

module quaternion_to_rotation_matrix_tb;

  localparam int unsigned RandomItems = 630;
  localparam int unsigned HoldAt      = 220;
  localparam int unsigned DrainAt     = 430;
  localparam int unsigned HoldCycles  = 150;

  typedef enum int unsigned {
    ReadyAlways,
    ReadyMostly,
    ReadyRarely,
    ReadyPeriodic
  } ready_mode_e;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  fix_t quat_x_i    = '0;
  fix_t quat_y_i    = '0;
  fix_t quat_z_i    = '0;
  fix_t quat_w_i    = '0;
  logic in_ready_o;
  logic out_valid_o;
  fix_t r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;
  logic degenerate_o;

  bit               hold_request = 1'b0;
  int unsigned      holds_done   = 0;
  matrix_scoreboard matrix_log   = new();
  matrix_t          seen_matrix;

  quaternion_to_rotation_matrix dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .quat_x_i    (quat_x_i),
    .quat_y_i    (quat_y_i),
    .quat_z_i    (quat_z_i),
    .quat_w_i    (quat_w_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .r00_o       (r00_o),
    .r01_o       (r01_o),
    .r02_o       (r02_o),
    .r10_o       (r10_o),
    .r11_o       (r11_o),
    .r12_o       (r12_o),
    .r20_o       (r20_o),
    .r21_o       (r21_o),
    .r22_o       (r22_o),
    .degenerate_o(degenerate_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 400000);
    $display("quaternion_to_rotation_matrix_tb: FAIL");
    $finish;
  end

  // matrix beat monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_matrix.entry[0]   = r00_o;
      seen_matrix.entry[1]   = r01_o;
      seen_matrix.entry[2]   = r02_o;
      seen_matrix.entry[3]   = r10_o;
      seen_matrix.entry[4]   = r11_o;
      seen_matrix.entry[5]   = r12_o;
      seen_matrix.entry[6]   = r20_o;
      seen_matrix.entry[7]   = r21_o;
      seen_matrix.entry[8]   = r22_o;
      seen_matrix.degenerate = degenerate_o;
      matrix_log.check_matrix(seen_matrix);
    end
  end

  // receiver stall pattern
  initial begin
    ready_mode_e mode;
    int unsigned seg_left;
    int unsigned hold_left;
    int unsigned phase;
    int unsigned period;
    logic        rdy;
    mode      = ReadyAlways;
    seg_left  = 0;
    hold_left = 0;
    phase     = 0;
    period    = 2;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
        if (hold_left == 0) holds_done++;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles - 1;
        rdy          = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = ready_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 150);
          period   = $urandom_range(2, 7);
          phase    = 0;
        end
        seg_left--;
        phase++;
        case (mode)
          ReadyAlways:   rdy = 1'b1;
          ReadyMostly:   rdy = ($urandom_range(0, 3) != 0);
          ReadyRarely:   rdy = ($urandom_range(0, 3) == 0);
          default:       rdy = ((phase % period) != 0);
        endcase
      end
      out_ready_i <= rdy;
    end
  end

  task automatic send_quat(input quat_t q);
    in_valid_i <= 1'b1;
    quat_x_i   <= q.x;
    quat_y_i   <= q.y;
    quat_z_i   <= q.z;
    quat_w_i   <= q.w;
    do @(posedge clk_i); while (!in_ready_o);
    matrix_log.note_quat(q);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (matrix_log.pending() != 0);
  endtask

  function automatic fix_t draw_component(int unsigned kind);
    case (kind)
      0, 1, 2, 3, 4: return fix_t'(int'($urandom_range(0, 32768)) - 16384);
      5, 6:          return fix_t'($urandom);
      7:             return fix_t'(int'($urandom_range(0, 8)) - 4);
      8: begin
        case ($urandom_range(0, 4))
          0:       return 16'h7fff;
          1:       return 16'h8000;
          2:       return 16'h0001;
          3:       return 16'hffff;
          default: return 16'h0000;
        endcase
      end
      default:       return ($urandom_range(0, 1) != 0) ? fix_t'($urandom) : fix_t'(0);
    endcase
  endfunction

  initial begin
    quat_t       corner_quats[$];
    quat_t       q;
    int unsigned kind;
    int unsigned burst_left;
    corner_quats = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000},
      '{16'h0000, 16'h0000, 16'h0000, 16'h4000},
      '{16'h4000, 16'h0000, 16'h0000, 16'h0000},
      '{16'h0000, 16'h4000, 16'h0000, 16'h0000},
      '{16'h0000, 16'h0000, 16'h4000, 16'h0000},
      '{16'hc000, 16'h0000, 16'h0000, 16'h0000},
      '{16'h0000, 16'h0000, 16'h0000, 16'hc000},
      '{16'h2000, 16'h2000, 16'h2000, 16'h2000},
      '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff},
      '{16'h8000, 16'h8000, 16'h8000, 16'h8000},
      '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000},
      '{16'h8000, 16'h0000, 16'h0000, 16'h0000},
      '{16'h0000, 16'h0000, 16'h0000, 16'h8000},
      '{16'h0000, 16'h0000, 16'h0000, 16'h0001},
      '{16'h0001, 16'h0001, 16'h0001, 16'h0001},
      '{16'hffff, 16'h0001, 16'hffff, 16'h0001},
      '{16'h2d41, 16'h0000, 16'h0000, 16'h2d41},
      '{16'h0000, 16'h2d41, 16'h0000, 16'h2d41},
      '{16'h0000, 16'h0000, 16'h2d41, 16'h2d41},
      '{16'h1234, 16'hedcb, 16'h5555, 16'haaaa},
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000},
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000}
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corner quaternions back to back
    foreach (corner_quats[i]) send_quat(corner_quats[i]);

    burst_left = 0;
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i == HoldAt) hold_request = 1'b1;
      if (i == DrainAt) wait_drained();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
      end
      burst_left--;
      kind = $urandom_range(0, 9);
      q.x  = draw_component(kind);
      q.y  = draw_component(kind);
      q.z  = draw_component(kind);
      q.w  = draw_component(kind);
      send_quat(q);
    end

    wait_drained();
    repeat (2 * q2rm_pkg::NumStages) @(negedge clk_i);

    $display("%0d quaternions sent, %0d matrices checked, %0d of them zero-norm identities",
             corner_quats.size() + RandomItems, matrix_log.checked, matrix_log.identities);
    $display("long output holds completed: %0d, with one full drain mid-run", holds_done);
    if (matrix_log.errors == 0 && matrix_log.pending() == 0) begin
      $display("quaternion_to_rotation_matrix_tb: PASS");
    end else begin
      $display("quaternion_to_rotation_matrix_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/q2rm_pkg.sv
rtl/quaternion_to_rotation_matrix.sv
rtl/q2rm_checker.sv
bench/quaternion_to_rotation_matrix_tb.sv
